### rtl/hsfd_pkg.sv
// Shared constants, position codes and the CRC-8 byte update for the
// humidity sensor frame decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [15:0] STATUS_BAD  = 16'hFFFF;
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  localparam int TDATA_W = 48;
  localparam int TUSER_W = 2;

  // Byte position inside a frame; POS_FIRST_HI also means no frame is open.
  localparam logic [2:0] POS_FIRST_HI  = 3'd0;
  localparam logic [2:0] POS_FIRST_LO  = 3'd1;
  localparam logic [2:0] POS_FIRST_CRC = 3'd2;
  localparam logic [2:0] POS_SECOND_HI = 3'd3;
  localparam logic [2:0] POS_SECOND_LO = 3'd4;
  localparam logic [2:0] POS_SECOND_CRC = 3'd5;

  localparam logic FRAME_MEAS   = 1'b0;
  localparam logic FRAME_STATUS = 1'b1;

  // One byte through the CRC-8 register, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/humidity_sensor_frame_decoder_core.sv
// Frame decoder top level: byte framing, CRC-8 check, and the fixed point
// conversion of temperature and humidity words. Depends on hsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one sensor byte per cycle and never stalls the input
// except when both internal result stages are full and the output is held.
// A measurement frame is six bytes and a status frame three; one result
// follows the last byte of a frame through the multiplier stage, which
// scales the raw words, and then the conversion stage, which divides by
// 65535 with a reciprocal add and applies the offset. Bytes outside a
// frame are dropped, and a new frame start abandons any open frame
// without a result. A CRC failure raises the error flag and forces the
// values to zero, or the status word to all ones.
module humidity_sensor_frame_decoder_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // [7:0] data_byte
  input  wire  [7:0]                   in_tdata,
  // [0] frame_start, [1] command
  input  wire  [hsfd_pkg::TUSER_W-1:0] in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // [14:0] temperature_centi, [28:15] humidity_centi, [44:29] status_word,
  // [47:45] zero
  output logic [hsfd_pkg::TDATA_W-1:0] out_tdata,
  // [0] frame_kind, [1] crc_error
  output logic [hsfd_pkg::TUSER_W-1:0] out_tuser
);
  import hsfd_pkg::*;

  // Frame state.
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] first_word_r, first_word_nxt;
  logic [7:0]  second_hi_r, second_hi_nxt;
  logic [7:0]  second_lo_r, second_lo_nxt;
  logic        err_r, err_nxt;
  logic        kind_r, kind_nxt;

  // Multiplier stage.
  logic        s1_v_r;
  logic        s1_kind_r;
  logic        s1_err_r;
  logic [15:0] s1_status_r;
  logic [30:0] s1_tprod_r;
  logic [29:0] s1_hprod_r;

  // Result register.
  logic        out_v_r;
  logic [TDATA_W-1:0] out_data_r;
  logic [TUSER_W-1:0] out_user_r;

  logic in_acc, emit, out_load, s1_adv;
  logic frame_start, command;
  logic [7:0] b;
  logic [2:0] pos_eff;
  logic [7:0] crc_base;
  logic err_base, kind_eff, err_chk;

  assign b           = in_tdata;
  assign frame_start = in_tuser[0];
  assign command     = in_tuser[1];

  assign out_load  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && out_load;
  assign in_tready = !s1_v_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  assign pos_eff  = frame_start ? POS_FIRST_HI : pos_r;
  assign crc_base = frame_start ? CRC_INIT : crc_r;
  assign err_base = frame_start ? 1'b0 : err_r;
  assign kind_eff = frame_start ? command : kind_r;
  assign err_chk  = err_base || (b != crc_base);

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    first_word_nxt = first_word_r;
    second_hi_nxt  = second_hi_r;
    second_lo_nxt  = second_lo_r;
    err_nxt        = err_r;
    kind_nxt       = kind_r;
    emit           = 1'b0;
    // A byte with no frame open is dropped without touching the state.
    if (in_acc && (frame_start || pos_r != POS_FIRST_HI)) begin
      err_nxt  = err_base;
      kind_nxt = kind_eff;
      crc_nxt  = crc_base;
      unique case (pos_eff)
        POS_FIRST_HI: begin
          first_word_nxt = {b, 8'h00};
          crc_nxt        = crc8_update(crc_base, b);
          pos_nxt        = POS_FIRST_LO;
        end
        POS_FIRST_LO: begin
          first_word_nxt = {first_word_r[15:8], b};
          crc_nxt        = crc8_update(crc_base, b);
          pos_nxt        = POS_FIRST_CRC;
        end
        POS_FIRST_CRC: begin
          err_nxt = err_chk;
          crc_nxt = CRC_INIT;
          if (kind_eff == FRAME_STATUS) begin
            emit    = 1'b1;
            pos_nxt = POS_FIRST_HI;
          end else begin
            pos_nxt = POS_SECOND_HI;
          end
        end
        POS_SECOND_HI: begin
          second_hi_nxt = b;
          crc_nxt       = crc8_update(crc_base, b);
          pos_nxt       = POS_SECOND_LO;
        end
        POS_SECOND_LO: begin
          second_lo_nxt = b;
          crc_nxt       = crc8_update(crc_base, b);
          pos_nxt       = POS_SECOND_CRC;
        end
        POS_SECOND_CRC: begin
          err_nxt = err_chk;
          crc_nxt = CRC_INIT;
          emit    = 1'b1;
          pos_nxt = POS_FIRST_HI;
        end
        default: begin
          pos_nxt = POS_FIRST_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_FIRST_HI;
      crc_r  <= CRC_INIT;
      err_r  <= 1'b0;
      kind_r <= FRAME_MEAS;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      err_r  <= err_nxt;
      kind_r <= kind_nxt;
    end
    first_word_r <= first_word_nxt;
    second_hi_r  <= second_hi_nxt;
    second_lo_r  <= second_lo_nxt;
  end

  // Multiplier stage: scale the stored raw words by the full-scale spans.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (emit) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
    if (emit) begin
      s1_kind_r   <= kind_eff;
      s1_err_r    <= err_chk;
      s1_status_r <= err_chk ? STATUS_BAD : first_word_r;
      s1_tprod_r  <= 31'(TEMP_SPAN) * 31'(first_word_r);
      s1_hprod_r  <= 30'(HUM_SPAN) * 30'({second_hi_r, second_lo_r});
    end
  end

  // Division by 65535 as (x + (x >> 16) + 1) >> 16, exact for quotients
  // below 65536.
  logic [31:0] tsum;
  logic [30:0] hsum;
  logic [15:0] tquot;
  logic [14:0] hquot;
  logic [15:0] temp_wide;
  logic [13:0] hum_val;
  logic [14:0] temp_o;
  logic [13:0] hum_o;
  logic [15:0] status_o;

  assign tsum      = 32'(s1_tprod_r) + 32'(s1_tprod_r[30:16]) + 32'd1;
  assign hsum      = 31'(s1_hprod_r) + 31'(s1_hprod_r[29:16]) + 31'd1;
  assign tquot     = tsum[31:16];
  assign hquot     = hsum[30:16];
  assign temp_wide = tquot - TEMP_OFFSET;
  assign hum_val   = (hquot > 15'(HUM_MAX)) ? HUM_MAX : hquot[13:0];

  always_comb begin
    temp_o   = '0;
    hum_o    = '0;
    status_o = '0;
    if (s1_kind_r == FRAME_STATUS) begin
      status_o = s1_status_r;
    end else if (!s1_err_r) begin
      temp_o = temp_wide[14:0];
      hum_o  = hum_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r;
    end
    if (s1_adv) begin
      out_data_r <= {3'b000, status_o, hum_o, temp_o};
      out_user_r <= {s1_err_r, s1_kind_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  // The frame position never leaves the six byte codes.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_SECOND_CRC)
    else $error("frame position out of range");

  // A stray byte with no open frame leaves the frame state alone.
  a_stray_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !frame_start && pos_r == POS_FIRST_HI) |=>
      (pos_r == POS_FIRST_HI) && $stable(crc_r) && $stable(err_r))
    else $error("stray byte changed frame state");

  // A stalled multiplier stage keeps its products.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_load) |=> s1_v_r && $stable(s1_tprod_r) && $stable(s1_hprod_r))
    else $error("multiplier stage lost its request");

  // A failed measurement reports zero values.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1] && !out_tuser[0]) |-> (out_tdata[28:0] == 29'd0))
    else $error("error result carries nonzero values");

  // Humidity never exceeds full scale.
  a_hum_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[28:15] <= HUM_MAX))
    else $error("humidity above full scale");
`endif

endmodule

`default_nettype wire
